>>> rtl/kss_pkg.sv
package kss_pkg;

   // table and vector geometry
   localparam int TableDepth   = 32;
   localparam int VectorLength = 64;

   localparam int SLOT_W      = (TableDepth > 1) ? $clog2(TableDepth) : 1;
   localparam int VEC_AW      = (VectorLength > 1) ? $clog2(VectorLength) : 1;
   localparam int CNT_W       = $clog2(VectorLength + 1);
   localparam int ENTRY_DEPTH = TableDepth * VectorLength;
   localparam int ENTRY_AW    = $clog2(ENTRY_DEPTH);
   localparam int SIM_W       = 48;

   // input actions
   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_QUERY  = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_CAND    = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_ELEM      = 2'd3;

   // query submap that matches no entry
   localparam logic [15:0] SUBMAP_NONE = 16'hFFFF;

   // controller to datapath commands
   typedef struct packed {
      logic              stage_wr;
      logic              del;
      logic              clr;
      logic              add_wr;
      logic              query_start;
      logic              copy_rd;
      logic              scan_step;
      logic              scan_first;
      logic              pick_commit;
      logic              dot_clear;
      logic              dot_rd;
      logic              best_upd;
      logic              emit;
      logic [1:0]        emit_kind;
      logic [1:0]        emit_status;
      logic [VEC_AW-1:0] vidx;
      logic [SLOT_W-1:0] sidx;
   } kss_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic             found;
      logic             full;
      logic             pick_valid;
      logic             pick_skip;
      logic             dot_busy;
      logic             above;
      logic             rsp_free;
      logic [CNT_W-1:0] len;
   } kss_stat_type;

endpackage

>>> rtl/kss_datapath.sv
module kss_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  kss_pkg::kss_cmd_type    cmd,
   output kss_pkg::kss_stat_type   stat,
   input  logic [15:0]             req_frame_id,
   input  logic signed [15:0]      req_submap_id,
   input  logic signed [15:0]      req_feature_value,
   input  logic                    req_element_last,
   input  logic                    csr_wr_en,
   input  logic signed [47:0]      csr_wr_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_result_kind,
   output logic [1:0]              rsp_status,
   output logic [15:0]             rsp_result_id,
   output logic signed [47:0]      rsp_similarity,
   output logic                    rsp_best_found,
   output logic                    rsp_result_last
);
   import kss_pkg::*;

   // table state
   logic [TableDepth-1:0] valid_ff;
   logic [15:0]           ids_ff  [TableDepth];
   logic [15:0]           subs_ff [TableDepth];
   logic [SLOT_W-1:0]     add_slot_ff;

   // memories
   logic [15:0] stage_mem [VectorLength];
   logic [15:0] entry_mem [ENTRY_DEPTH];
   logic [15:0] stage_q_ff;
   logic [15:0] entry_q_ff;

   // element stream
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] len_ff;
   logic [CNT_W-1:0] new_len;

   // copy pipeline
   logic              cp_v_ff;
   logic [VEC_AW-1:0] cp_idx_ff;

   // query state
   logic [15:0]       q_smap_ff;
   logic              have_prev_ff;
   logic [15:0]       prev_ff;
   logic              pick_valid_ff;
   logic [SLOT_W-1:0] pick_slot_ff;
   logic [15:0]       pick_id_ff;
   logic signed [SIM_W-1:0] thr_ff;
   logic signed [SIM_W-1:0] acc_ff;
   logic signed [SIM_W-1:0] best_sim_ff;
   logic [15:0]       best_id_ff;
   logic              best_found_ff;
   logic              rd_v_ff;
   logic              mul_v_ff;
   logic signed [31:0] prod_ff;

   // response register
   logic              rsp_valid_ff;
   logic [1:0]        rsp_kind_ff;
   logic [1:0]        rsp_status_ff;
   logic [15:0]       rsp_id_ff;
   logic signed [SIM_W-1:0] rsp_sim_ff;
   logic              rsp_found_ff;

   // lookup signals
   logic [TableDepth-1:0] match;
   logic                  found;
   logic [SLOT_W-1:0]     hit_slot;
   logic [SLOT_W-1:0]     free_slot;
   logic [SLOT_W-1:0]     slot_sel;
   logic [15:0]           scan_id;
   logic                  scan_ok;
   logic                  scan_take;
   logic [ENTRY_AW-1:0]   rd_addr;
   logic [ENTRY_AW-1:0]   wr_addr;
   logic                  rsp_free;

   // parallel id lookup with lowest-slot priority
   always_comb begin
      match     = '0;
      hit_slot  = '0;
      free_slot = '0;
      for (int i = 0; i < TableDepth; i++) begin
         match[i] = valid_ff[i] && (ids_ff[i] == req_frame_id);
      end
      for (int i = TableDepth - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_slot = SLOT_W'(i);
         end
         if (!valid_ff[i]) begin
            free_slot = SLOT_W'(i);
         end
      end
   end

   assign found    = |match;
   assign slot_sel = found ? hit_slot : free_slot;

   // table valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.clr) begin
         valid_ff <= '0;
      end else begin
         if (cmd.del && found) begin
            valid_ff[hit_slot] <= 1'b0;
         end
         if (cmd.add_wr) begin
            valid_ff[slot_sel] <= 1'b1;
         end
      end
   end

   // table id and submap
   always_ff @(posedge clock) begin
      if (cmd.add_wr) begin
         ids_ff[slot_sel]  <= req_frame_id;
         subs_ff[slot_sel] <= req_submap_id;
         add_slot_ff       <= slot_sel;
      end
   end

   // element counter and vector length
   assign new_len = (count_ff < CNT_W'(VectorLength)) ? count_ff + CNT_W'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.stage_wr) begin
         count_ff <= req_element_last ? '0 : new_len;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.stage_wr && req_element_last) begin
         len_ff <= new_len;
      end
   end

   // staging memory
   always_ff @(posedge clock) begin
      if (cmd.stage_wr && (count_ff < CNT_W'(VectorLength))) begin
         stage_mem[count_ff[VEC_AW-1:0]] <= req_feature_value;
      end
      stage_q_ff <= stage_mem[cmd.vidx];
   end

   // entry memory
   assign rd_addr = ENTRY_AW'(pick_slot_ff) * ENTRY_AW'(VectorLength) + ENTRY_AW'(cmd.vidx);
   assign wr_addr = ENTRY_AW'(add_slot_ff) * ENTRY_AW'(VectorLength) + ENTRY_AW'(cp_idx_ff);

   always_ff @(posedge clock) begin
      if (cp_v_ff) begin
         entry_mem[wr_addr] <= (CNT_W'(cp_idx_ff) < len_ff) ? stage_q_ff : 16'd0;
      end
      entry_q_ff <= entry_mem[rd_addr];
   end

   // copy pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         cp_v_ff <= 1'b0;
      end else begin
         cp_v_ff <= cmd.copy_rd;
      end
      cp_idx_ff <= cmd.vidx;
   end

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // ascending id scan
   assign scan_id   = ids_ff[cmd.sidx];
   assign scan_ok   = valid_ff[cmd.sidx] && (!have_prev_ff || (scan_id > prev_ff));
   assign scan_take = cmd.scan_first ? scan_ok
                                     : (scan_ok && (!pick_valid_ff || (scan_id < pick_id_ff)));

   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         q_smap_ff    <= req_submap_id;
         have_prev_ff <= 1'b0;
      end else if (cmd.pick_commit) begin
         have_prev_ff <= 1'b1;
         prev_ff      <= pick_id_ff;
      end
      if (cmd.scan_step) begin
         if (cmd.scan_first) begin
            pick_valid_ff <= scan_ok;
         end else if (scan_take) begin
            pick_valid_ff <= 1'b1;
         end
         if (scan_take) begin
            pick_slot_ff <= cmd.sidx;
            pick_id_ff   <= scan_id;
         end
      end
   end

   // dot product pipeline: read, multiply, accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff  <= 1'b0;
         mul_v_ff <= 1'b0;
      end else begin
         rd_v_ff  <= cmd.dot_rd;
         mul_v_ff <= rd_v_ff;
      end
      prod_ff <= $signed(stage_q_ff) * $signed(entry_q_ff);
      if (cmd.dot_clear) begin
         acc_ff <= '0;
      end else if (mul_v_ff) begin
         acc_ff <= acc_ff + {{(SIM_W - 32){prod_ff[31]}}, prod_ff};
      end
   end

   // best tracking
   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         best_sim_ff   <= '0;
         best_id_ff    <= '0;
         best_found_ff <= 1'b0;
      end else if (cmd.best_upd && (acc_ff > best_sim_ff)) begin
         best_sim_ff   <= acc_ff;
         best_id_ff    <= pick_id_ff;
         best_found_ff <= 1'b1;
      end
   end

   // response register
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff <= cmd.emit_kind;
         unique case (cmd.emit_kind)
            KIND_CAND: begin
               rsp_status_ff <= ST_OK;
               rsp_id_ff     <= pick_id_ff;
               rsp_sim_ff    <= acc_ff;
               rsp_found_ff  <= 1'b0;
            end
            KIND_SUMMARY: begin
               rsp_status_ff <= ST_OK;
               rsp_id_ff     <= best_id_ff;
               rsp_sim_ff    <= best_sim_ff;
               rsp_found_ff  <= best_found_ff;
            end
            default: begin
               rsp_status_ff <= cmd.emit_status;
               rsp_id_ff     <= '0;
               rsp_sim_ff    <= '0;
               rsp_found_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_id   = rsp_id_ff;
   assign rsp_similarity  = rsp_sim_ff;
   assign rsp_best_found  = rsp_found_ff;
   assign rsp_result_last = (rsp_kind_ff != KIND_CAND);

   // status to controller
   assign stat.found      = found;
   assign stat.full       = !found && (&valid_ff);
   assign stat.pick_valid = pick_valid_ff;
   assign stat.pick_skip  = (q_smap_ff != SUBMAP_NONE) && (q_smap_ff == subs_ff[pick_slot_ff]);
   assign stat.dot_busy   = rd_v_ff || mul_v_ff;
   assign stat.above      = acc_ff > thr_ff;
   assign stat.rsp_free   = rsp_free;
   assign stat.len        = len_ff;

endmodule

>>> rtl/kss_ctrl.sv
module kss_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_action,
   input  logic                  req_element_last,
   input  kss_pkg::kss_stat_type stat,
   output kss_pkg::kss_cmd_type  cmd
);
   import kss_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_COPY,
      S_COPY_END,
      S_SCAN,
      S_SCAN_END,
      S_DOT,
      S_DOT_WAIT,
      S_EVAL
   } state_type;

   state_type         state_ff, state_in;
   logic [VEC_AW-1:0] vidx_ff, vidx_in;
   logic [SLOT_W-1:0] sidx_ff, sidx_in;
   logic              summary_ff, summary_in;
   logic              accept;

   // input held off while a summary is still pending
   assign req_ready = (state_ff == S_IDLE) && !summary_ff && stat.rsp_free;
   assign accept    = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      vidx_in    = vidx_ff;
      sidx_in    = sidx_ff;
      summary_in = summary_ff;
      cmd        = '0;
      cmd.vidx   = vidx_ff;
      cmd.sidx   = sidx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (summary_ff) begin
               // summary waits for the response register
               if (stat.rsp_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = KIND_SUMMARY;
                  summary_in    = 1'b0;
               end
            end else if (accept) begin
               unique case (req_action)
                  ACT_DELETE: begin
                     cmd.del         = 1'b1;
                     cmd.emit        = 1'b1;
                     cmd.emit_kind   = KIND_STATUS;
                     cmd.emit_status = stat.found ? ST_OK : ST_NOT_FOUND;
                  end
                  ACT_CLEAR: begin
                     cmd.clr         = 1'b1;
                     cmd.emit        = 1'b1;
                     cmd.emit_kind   = KIND_STATUS;
                     cmd.emit_status = ST_OK;
                  end
                  default: begin
                     cmd.stage_wr = 1'b1;
                     if (!req_element_last) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_kind   = KIND_STATUS;
                        cmd.emit_status = ST_ELEM;
                     end else if (req_action == ACT_ADD) begin
                        if (stat.full) begin
                           cmd.emit        = 1'b1;
                           cmd.emit_kind   = KIND_STATUS;
                           cmd.emit_status = ST_FULL;
                        end else begin
                           cmd.add_wr = 1'b1;
                           vidx_in    = '0;
                           state_in   = S_COPY;
                        end
                     end else begin
                        cmd.query_start = 1'b1;
                        sidx_in         = '0;
                        state_in        = S_SCAN;
                     end
                  end
               endcase
            end
         end
         S_COPY: begin
            cmd.copy_rd = 1'b1;
            vidx_in     = vidx_ff + VEC_AW'(1);
            if (CNT_W'(vidx_ff) == CNT_W'(VectorLength - 1)) begin
               state_in = S_COPY_END;
            end
         end
         S_COPY_END: begin
            if (stat.rsp_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_kind   = KIND_STATUS;
               cmd.emit_status = ST_OK;
               state_in        = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_step  = 1'b1;
            cmd.scan_first = (sidx_ff == '0);
            sidx_in        = sidx_ff + SLOT_W'(1);
            if (sidx_ff == SLOT_W'(TableDepth - 1)) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            sidx_in = '0;
            vidx_in = '0;
            if (!stat.pick_valid) begin
               summary_in = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.pick_commit = 1'b1;
               if (stat.pick_skip) begin
                  state_in = S_SCAN;
               end else begin
                  cmd.dot_clear = 1'b1;
                  state_in      = S_DOT;
               end
            end
         end
         S_DOT: begin
            cmd.dot_rd = 1'b1;
            vidx_in    = vidx_ff + VEC_AW'(1);
            if (CNT_W'(vidx_ff) + CNT_W'(1) >= stat.len) begin
               state_in = S_DOT_WAIT;
            end
         end
         S_DOT_WAIT: begin
            if (!stat.dot_busy) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!stat.above || stat.rsp_free) begin
               cmd.best_upd  = 1'b1;
               cmd.emit      = stat.above;
               cmd.emit_kind = KIND_CAND;
               sidx_in       = '0;
               state_in      = S_SCAN;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         vidx_ff    <= '0;
         sidx_ff    <= '0;
         summary_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         vidx_ff    <= vidx_in;
         sidx_ff    <= sidx_in;
         summary_ff <= summary_in;
      end
   end

endmodule

>>> rtl/keyframe_similarity_search_top.sv
// element transactions (add or query, not last), delete and clear: one per cycle while the
//   response register is free, status registered in the cycle after acceptance
// add completion: set by the staging-to-entry memory copy
// query completion: set by a serial id scan per picked entry and the single-port
//   multiply-accumulate over each scored entry
// reset (synchronous, active high) empties the table, the element count and the threshold
module keyframe_similarity_search_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [15:0]        req_frame_id,
   input  logic signed [15:0] req_submap_id,
   input  logic signed [15:0] req_feature_value,
   input  logic               req_element_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_result_kind,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_result_id,
   output logic signed [47:0] rsp_similarity,
   output logic               rsp_best_found,
   output logic               rsp_result_last,
   input  logic               csr_wr_en,
   input  logic signed [47:0] csr_wr_data
);
   import kss_pkg::*;

   kss_cmd_type  cmd;
   kss_stat_type stat;

   // sequencer
   kss_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_element_last (req_element_last),
      .stat             (stat),
      .cmd              (cmd)
   );

   // table, memories and arithmetic
   kss_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_frame_id      (req_frame_id),
      .req_submap_id     (req_submap_id),
      .req_feature_value (req_feature_value),
      .req_element_last  (req_element_last),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_status        (rsp_status),
      .rsp_result_id     (rsp_result_id),
      .rsp_similarity    (rsp_similarity),
      .rsp_best_found    (rsp_best_found),
      .rsp_result_last   (rsp_result_last)
   );

endmodule

>>> sim/keyframe_similarity_search_top_tb.sv
module keyframe_similarity_search_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kss_pkg::*;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [15:0] id;
      logic [47:0] sim;
      logic        found;
      logic        last;
   } search_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_action = ACT_CLEAR;
   logic [15:0]        req_frame_id = '0;
   logic signed [15:0] req_submap_id = '0;
   logic signed [15:0] req_feature_value = '0;
   logic               req_element_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_result_kind;
   logic [1:0]         rsp_status;
   logic [15:0]        rsp_result_id;
   logic signed [47:0] rsp_similarity;
   logic               rsp_best_found;
   logic               rsp_result_last;
   logic               csr_wr_en = 1'b0;
   logic signed [47:0] csr_wr_data = '0;

   keyframe_similarity_search_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_frame_id      (req_frame_id),
      .req_submap_id     (req_submap_id),
      .req_feature_value (req_feature_value),
      .req_element_last  (req_element_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_status        (rsp_status),
      .rsp_result_id     (rsp_result_id),
      .rsp_similarity    (rsp_similarity),
      .rsp_best_found    (rsp_best_found),
      .rsp_result_last   (rsp_result_last),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #5 clock = ~clock;

   // shadow copy of the keyframe table
   logic signed [15:0] shadow_vec [TableDepth][VectorLength];
   logic [15:0]        shadow_id [TableDepth];
   logic signed [15:0] shadow_submap [TableDepth];
   bit                 shadow_used [TableDepth];
   logic signed [15:0] staged_elems [VectorLength];
   int                 staged_count = 0;
   logic signed [47:0] threshold = '0;

   search_result_type pending_results[$];
   int             errors = 0;
   int             hold_cycles = 0;
   int             ready_gap = 0;
   bit             steady = 1'b0;
   logic [15:0]    id_pool [16];

   function automatic int pick_gap();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
   endfunction

   function automatic void push_result(logic [1:0] kind, logic [1:0] st, logic [15:0] id,
                                       logic [47:0] sim, logic found, logic last);
      search_result_type r;
      r = '{kind, st, id, sim, found, last};
      pending_results.insert(pending_results.size(), r);
   endfunction

   // expected results of one accepted transaction
   function automatic void predict_search(logic [1:0] act, logic [15:0] fid,
                                          logic signed [15:0] smap,
                                          logic signed [15:0] feat, logic lst);
      int     hit;
      int     cnt;
      int     pick;
      longint score;
      longint best_sim;
      logic [15:0] best_id;
      logic [15:0] prev;
      bit     found;
      bit     have_prev;
      hit = -1;
      for (int i = TableDepth - 1; i >= 0; i--)
         if (shadow_used[i] && shadow_id[i] == fid) hit = i;
      case (act)
         ACT_DELETE: begin
            if (hit >= 0) shadow_used[hit] = 1'b0;
            push_result(KIND_STATUS, (hit >= 0) ? ST_OK : ST_NOT_FOUND, '0, '0, 1'b0, 1'b1);
         end
         ACT_CLEAR: begin
            for (int i = 0; i < TableDepth; i++) shadow_used[i] = 1'b0;
            push_result(KIND_STATUS, ST_OK, '0, '0, 1'b0, 1'b1);
         end
         default: begin
            if (staged_count < VectorLength) begin
               staged_elems[staged_count] = feat;
               staged_count++;
            end
            if (!lst) begin
               push_result(KIND_STATUS, ST_ELEM, '0, '0, 1'b0, 1'b1);
            end else begin
               cnt = staged_count;
               staged_count = 0;
               if (act == ACT_ADD) begin
                  if (hit < 0)
                     for (int i = 0; i < TableDepth; i++)
                        if (!shadow_used[i] && hit < 0) hit = i;
                  if (hit < 0) begin
                     push_result(KIND_STATUS, ST_FULL, '0, '0, 1'b0, 1'b1);
                  end else begin
                     shadow_used[hit] = 1'b1;
                     shadow_id[hit] = fid;
                     shadow_submap[hit] = smap;
                     for (int k = 0; k < VectorLength; k++)
                        shadow_vec[hit][k] = (k < cnt) ? staged_elems[k] : 16'sd0;
                     push_result(KIND_STATUS, ST_OK, '0, '0, 1'b0, 1'b1);
                  end
               end else begin
                  // walk entries in ascending id order
                  best_sim = 0;
                  best_id = '0;
                  found = 1'b0;
                  have_prev = 1'b0;
                  prev = '0;
                  for (int n = 0; n < TableDepth; n++) begin
                     pick = -1;
                     for (int i = 0; i < TableDepth; i++)
                        if (shadow_used[i] && !(have_prev && shadow_id[i] <= prev))
                           if (pick < 0 || shadow_id[i] < shadow_id[pick]) pick = i;
                     if (pick < 0) break;
                     have_prev = 1'b1;
                     prev = shadow_id[pick];
                     if (smap == SUBMAP_NONE || smap != shadow_submap[pick]) begin
                        score = 0;
                        for (int k = 0; k < cnt && k < VectorLength; k++)
                           score += longint'(staged_elems[k]) * longint'(shadow_vec[pick][k]);
                        if (score > 64'sd140737488355327) score = 64'sd140737488355327;
                        if (score < -64'sd140737488355328) score = -64'sd140737488355328;
                        if (score > longint'(threshold))
                           push_result(KIND_CAND, ST_OK, shadow_id[pick], score[47:0], 1'b0,
                                       1'b0);
                        if (score > best_sim) begin
                           best_sim = score;
                           best_id = shadow_id[pick];
                           found = 1'b1;
                        end
                     end
                  end
                  push_result(KIND_SUMMARY, ST_OK, best_id, best_sim[47:0], found, 1'b1);
               end
            end
         end
      endcase
   endfunction

   // request monitor feeds the predictor
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         predict_search(req_action, req_frame_id, req_submap_id, req_feature_value,
                        req_element_last);
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // result checker
   always @(posedge clock) begin
      search_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result kind", 64'(rsp_result_kind), 64'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_kind !== want.kind)
               report_mismatch("kind", 64'(rsp_result_kind), 64'(want.kind));
            if (rsp_status !== want.status)
               report_mismatch("status", 64'(rsp_status), 64'(want.status));
            if (rsp_result_id !== want.id)
               report_mismatch("id", 64'(rsp_result_id), 64'(want.id));
            if (rsp_similarity !== want.sim)
               report_mismatch("similarity", 64'(rsp_similarity), 64'(want.sim));
            if (rsp_best_found !== want.found)
               report_mismatch("best_found", 64'(rsp_best_found), 64'(want.found));
            if (rsp_result_last !== want.last)
               report_mismatch("last", 64'(rsp_result_last), 64'(want.last));
         end
      end
   end

   // receiver stalls, with an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles--;
      end else if (steady) begin
         rsp_ready <= 1'b1;
      end else if (ready_gap > 0) begin
         rsp_ready <= 1'b0;
         ready_gap--;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) ready_gap = pick_gap();
      end
   end

   task automatic send_item(logic [1:0] act, logic [15:0] fid, logic signed [15:0] smap,
                            logic signed [15:0] feat, logic lst);
      int gap;
      gap = (steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_frame_id <= fid;
      req_submap_id <= smap;
      req_feature_value <= feat;
      req_element_last <= lst;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   function automatic logic signed [15:0] rand_feature();
      case ($urandom_range(0, 5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic signed [15:0] rand_submap();
      case ($urandom_range(0, 3))
         0: return SUBMAP_NONE;
         3: return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(0, 2));
      endcase
   endfunction

   task automatic send_vector(logic [1:0] act, logic [15:0] fid, logic signed [15:0] smap,
                              int len);
      for (int k = 0; k < len; k++)
         send_item(act, fid, smap, rand_feature(), k == len - 1);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_threshold(logic signed [47:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      threshold = value;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // extremes, replace, submap skip, delete mid-stream and clear
   task automatic test_directed();
      send_item(ACT_CLEAR, 16'h1234, 16'sh5555, 16'sh2AAA, 1'b1);
      send_item(ACT_DELETE, 16'hFFFF, 16'shAAAA, 16'sh5555, 1'b0);
      send_item(ACT_ADD, 16'h0000, 16'sd5, 16'sh7FFF, 1'b0);
      send_item(ACT_ADD, 16'h0000, 16'sd5, 16'sh8000, 1'b1);
      send_item(ACT_ADD, 16'hFFFF, SUBMAP_NONE, 16'sh8000, 1'b0);
      send_item(ACT_DELETE, 16'h0BAD, 16'sh7FFF, 16'sh7FFF, 1'b1);
      send_item(ACT_ADD, 16'hFFFF, SUBMAP_NONE, 16'sh8000, 1'b1);
      send_item(ACT_QUERY, 16'h0000, SUBMAP_NONE, 16'sh7FFF, 1'b0);
      send_item(ACT_QUERY, 16'h0000, SUBMAP_NONE, 16'sh8000, 1'b1);
      send_item(ACT_QUERY, 16'h0000, 16'sd5, 16'sh8000, 1'b1);
      send_item(ACT_QUERY, 16'h0000, 16'sh7FFF, 16'sh0000, 1'b1);
      send_item(ACT_ADD, 16'h0000, 16'sh7FFF, 16'sh7FFF, 1'b1);
      send_item(ACT_QUERY, 16'h0000, SUBMAP_NONE, 16'sh7FFF, 1'b1);
      send_item(ACT_DELETE, 16'hFFFF, 16'sd0, 16'sd0, 1'b0);
      send_item(ACT_DELETE, 16'hFFFF, 16'sd0, 16'sd0, 1'b0);
      send_item(ACT_QUERY, 16'h0000, SUBMAP_NONE, 16'sh8000, 1'b1);
      send_item(ACT_CLEAR, 16'h0000, 16'sd0, 16'sd0, 1'b0);
      send_item(ACT_QUERY, 16'h0000, SUBMAP_NONE, 16'sh8000, 1'b1);
   endtask

   // threshold extremes with a small populated table
   task automatic test_thresholds();
      logic signed [47:0] values [4];
      values = '{48'sh7FFF_FFFF_FFFF, 48'sh8000_0000_0000, -48'sd1000, 48'sd0};
      send_vector(ACT_ADD, 16'h0010, 16'sd1, 2);
      send_vector(ACT_ADD, 16'h0005, 16'sd2, 1);
      send_vector(ACT_ADD, 16'h00A0, SUBMAP_NONE, 1);
      foreach (values[i]) begin
         write_threshold(values[i]);
         send_vector(ACT_QUERY, 16'h0000, SUBMAP_NONE, 1);
         send_vector(ACT_QUERY, 16'h0000, 16'sd1, 1);
      end
   endtask

   // fill the table, overflow it, replace while full, score every entry whose submap differs from the query's
   task automatic test_table_full();
      send_item(ACT_CLEAR, 16'h0000, 16'sd0, 16'sd0, 1'b0);
      for (int i = 0; i < TableDepth; i++)
         send_item(ACT_ADD, 16'(i * 2053 + 7), rand_submap(), rand_feature(), 1'b1);
      send_item(ACT_ADD, 16'hBEEF, 16'sd0, 16'sd1, 1'b1);
      send_item(ACT_ADD, 16'd7, 16'sd3, 16'sh8000, 1'b1);
      write_threshold(48'sh8000_0000_0000);
      send_item(ACT_QUERY, 16'h0000, 16'sd1, 16'sh7FFF, 1'b1);
   endtask

   // vectors longer than the staging buffer drop the extra elements
   task automatic test_long_vector();
      send_item(ACT_CLEAR, 16'h0000, 16'sd0, 16'sd0, 1'b0);
      send_vector(ACT_ADD, 16'h0042, 16'sd9, VectorLength + 1);
      send_vector(ACT_QUERY, 16'h0000, SUBMAP_NONE, 1);
   endtask

   // receiver holds off while elements keep arriving
   task automatic test_pressure();
      wait_idle();
      hold_cycles = 400;
      send_vector(ACT_QUERY, 16'h0000, SUBMAP_NONE, 6);
      wait_idle();
   endtask

   // random phases of well-formed vectors mixed with deletes and clears
   task automatic test_random();
      int sent;
      int len;
      logic signed [47:0] phase_thr;
      foreach (id_pool[i]) id_pool[i] = 16'($urandom_range(0, 65535));
      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hFFFF;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: phase_thr = $signed(48'($urandom_range(0, 1 << 30))) - 48'sd536870912;
            1: phase_thr = {16'($urandom_range(0, 65535)), $urandom()};
            2: phase_thr = -48'sd1;
            default: phase_thr = 48'($urandom_range(0, 1 << 28));
         endcase
         write_threshold(phase_thr);
         steady = (phase == 2);
         sent = 0;
         while (sent < 3) begin
            case ($urandom_range(0, 19))
               0, 1: begin
                  send_item(ACT_DELETE, id_pool[$urandom_range(0, 15)],
                            16'($urandom_range(0, 65535)), rand_feature(),
                            1'($urandom_range(0, 1)));
                  sent++;
               end
               2: begin
                  send_item(ACT_CLEAR, 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)), rand_feature(),
                            1'($urandom_range(0, 1)));
                  sent++;
               end
               default: begin
                  len = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 8)
                                                     : $urandom_range(1, 3);
                  send_vector($urandom_range(0, 2) == 0 ? ACT_QUERY : ACT_ADD,
                              id_pool[$urandom_range(0, 15)], rand_submap(), len);
                  sent += len;
               end
            endcase
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < TableDepth; i++) shadow_used[i] = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_thresholds();
      test_table_full();
      test_long_vector();
      test_pressure();
      test_random();
      wait_idle();
      repeat (200) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // run limit
   initial begin
      #50ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
